FILE: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int SLOTS       = 64;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int COUNT_BITS  = $clog2(SLOTS + 1);
    localparam int SYMBOL_BITS = 32;
    localparam int CLASS_BITS  = 4;
    localparam int HANDLE_BITS = 32;
    localparam int ENTRY_BITS  = SYMBOL_BITS + CLASS_BITS + HANDLE_BITS;

    // mixing constants of the home slot hash
    localparam logic [63:0] MIX_A = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_B = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] MIX_C = 64'hBF58476D1CE4E5B9;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // operand selection of the shared hash multiplier
    typedef enum logic [2:0] {
        H_NONE,
        H_SYM_LO,
        H_SYM_HI,
        H_CLS_LO,
        H_CLS_HI,
        H_FIN_LO
    } t_hop;

    typedef struct packed {
        logic load;
        t_hop hop;
        logic mix;
        logic home;
        logic rd;
        logic advance;
        logic commit_found;
        logic commit_full;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic key_match;
        logic last_probe;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/lpht_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpht_req_if;
    import lpht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [SYMBOL_BITS-1:0] symbol_id;
    logic [CLASS_BITS-1:0]  entry_class;
    logic [HANDLE_BITS-1:0] handle;

    modport source (output valid, kind, symbol_id, entry_class, handle, input ready);
    modport sink   (input valid, kind, symbol_id, entry_class, handle, output ready);
endinterface

interface lpht_rsp_if;
    import lpht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [HANDLE_BITS-1:0] found_handle;
    logic                   updated_existing;
    logic                   refused_full;
    logic [COUNT_BITS-1:0]  entry_count;

    modport source (output valid, hit, found_handle, updated_existing, refused_full,
                    entry_count, input ready);
    modport sink   (input valid, hit, found_handle, updated_existing, refused_full,
                    entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/lpht_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/lpht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire lpht_pkg::t_sts  i_sts,
    output lpht_pkg::t_cmd       o_cmd
);
    import lpht_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_H0,
        S_H1,
        S_H2,
        S_H3,
        S_H4,
        S_H5,
        S_H6,
        S_RD,
        S_CMP,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    t_cmd   w_cmd;
    logic   w_stop;

    assign w_stop = i_sts.slot_free || i_sts.key_match;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.hop = H_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && r_ready) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_H0;
                end
            end
            S_H0: begin
                w_cmd.hop = H_SYM_LO;
                n_state   = S_H1;
            end
            S_H1: begin
                w_cmd.hop = H_SYM_HI;
                n_state   = S_H2;
            end
            S_H2: begin
                w_cmd.hop = H_CLS_LO;
                n_state   = S_H3;
            end
            S_H3: begin
                w_cmd.hop = H_CLS_HI;
                n_state   = S_H4;
            end
            S_H4: begin
                w_cmd.mix = 1'b1;
                n_state   = S_H5;
            end
            S_H5: begin
                w_cmd.hop = H_FIN_LO;
                n_state   = S_H6;
            end
            S_H6: begin
                w_cmd.home = 1'b1;
                n_state    = S_RD;
            end
            S_RD: begin
                w_cmd.rd = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (w_stop) begin
                    w_cmd.commit_found = 1'b1;
                    n_state            = S_FIN;
                end else if (i_sts.last_probe) begin
                    w_cmd.commit_full = 1'b1;
                    n_state           = S_FIN;
                end else begin
                    w_cmd.advance = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_req_ready = r_ready;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

FILE: rtl/lpht_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lpht_pkg::t_cmd                   i_cmd,
    output lpht_pkg::t_sts                        o_sts,
    input  wire logic                             i_kind,
    input  wire logic [lpht_pkg::SYMBOL_BITS-1:0] i_symbol_id,
    input  wire logic [lpht_pkg::CLASS_BITS-1:0]  i_entry_class,
    input  wire logic [lpht_pkg::HANDLE_BITS-1:0] i_handle,
    lpht_rsp_if.source                            o_rsp
);
    import lpht_pkg::*;

    // item registers
    logic                   r_kind;
    logic [SYMBOL_BITS-1:0] r_sym;
    logic [CLASS_BITS-1:0]  r_cls;
    logic [HANDLE_BITS-1:0] r_hnd;

    // hash unit
    logic [63:0]          r_acc;
    logic [63:0]          r_prod;
    logic                 r_pend;
    logic                 r_pend_hi;
    logic [SLOT_BITS-1:0] r_t;
    logic [31:0]          w_mul_a;
    logic [31:0]          w_mul_b;
    logic [63:0]          w_prod;
    logic [63:0]          w_addend;
    logic [63:0]          w_sum;
    logic [63:0]          w_mixed;
    logic [SLOT_BITS-1:0] w_small;
    logic [SLOT_BITS-1:0] w_home;

    // probe and table state
    logic [SLOT_BITS-1:0]  r_idx;
    logic [SLOT_BITS-1:0]  r_n;
    logic [SLOTS-1:0]      r_valid;
    logic [COUNT_BITS-1:0] r_count;
    logic                  w_we;
    logic [ENTRY_BITS-1:0] w_rdata;
    logic [SYMBOL_BITS-1:0] w_rd_sym;
    logic [CLASS_BITS-1:0]  w_rd_cls;
    logic [HANDLE_BITS-1:0] w_rd_hnd;
    logic                   w_free;

    // pending result and output register
    logic                   r_res_hit;
    logic                   r_res_upd;
    logic                   r_res_ref;
    logic [HANDLE_BITS-1:0] r_res_found;
    logic                   r_out_valid;
    logic                   r_out_hit;
    logic                   r_out_upd;
    logic                   r_out_ref;
    logic [HANDLE_BITS-1:0] r_out_found;
    logic [COUNT_BITS-1:0]  r_out_count;

    always_comb begin
        case (i_cmd.hop)
            H_SYM_LO: begin
                w_mul_a = 32'(r_sym);
                w_mul_b = MIX_A[31:0];
            end
            H_SYM_HI: begin
                w_mul_a = 32'(r_sym);
                w_mul_b = MIX_A[63:32];
            end
            H_CLS_LO: begin
                w_mul_a = 32'(r_cls) + 32'd1;
                w_mul_b = MIX_B[31:0];
            end
            H_CLS_HI: begin
                w_mul_a = 32'(r_cls) + 32'd1;
                w_mul_b = MIX_B[63:32];
            end
            H_FIN_LO: begin
                w_mul_a = r_acc[31:0];
                w_mul_b = MIX_C[31:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod   = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_addend = !r_pend ? 64'd0 : (r_pend_hi ? {r_prod[31:0], 32'd0} : r_prod);
    assign w_sum    = r_acc + w_addend;
    assign w_mixed  = w_sum ^ (w_sum >> 29);

    // cross terms of the final product only reach the slot bits through their low bits
    assign w_small = SLOT_BITS'(r_acc[SLOT_BITS-1:0] * MIX_C[32 +: SLOT_BITS])
                   + SLOT_BITS'(r_acc[32 +: SLOT_BITS] * MIX_C[SLOT_BITS-1:0]);
    assign w_home  = r_prod[SLOT_BITS-1:0] ^ (r_prod[32 +: SLOT_BITS] + r_t);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_sym  <= i_symbol_id;
            r_cls  <= i_entry_class;
            r_hnd  <= i_handle;
            r_acc  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.mix) begin
            r_acc  <= w_mixed;
            r_pend <= 1'b0;
        end else begin
            case (i_cmd.hop) inside
                H_SYM_LO, H_SYM_HI, H_CLS_LO, H_CLS_HI: begin
                    r_acc     <= w_sum;
                    r_prod    <= w_prod;
                    r_pend    <= 1'b1;
                    r_pend_hi <= (i_cmd.hop == H_SYM_HI) || (i_cmd.hop == H_CLS_HI);
                end
                H_FIN_LO: begin
                    r_prod <= w_prod;
                    r_t    <= w_small;
                    r_pend <= 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.home) begin
            r_idx <= w_home;
            r_n   <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + 1'b1;
            r_n   <= r_n + 1'b1;
        end
    end

    assign w_we = i_cmd.commit_found && (r_kind == KIND_INSERT);

    lpht_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (i_cmd.rd),
        .i_we    (w_we),
        .i_addr  (r_idx),
        .i_wdata ({r_sym, r_cls, r_hnd}),
        .o_rdata (w_rdata)
    );

    assign w_rd_sym = w_rdata[ENTRY_BITS-1 -: SYMBOL_BITS];
    assign w_rd_cls = w_rdata[HANDLE_BITS +: CLASS_BITS];
    assign w_rd_hnd = w_rdata[HANDLE_BITS-1:0];
    assign w_free   = !r_valid[r_idx];

    assign o_sts.slot_free  = w_free;
    assign o_sts.key_match  = !w_free && (w_rd_sym == r_sym) && (w_rd_cls == r_cls);
    assign o_sts.last_probe = (r_n == SLOT_BITS'(SLOTS - 1));
    assign o_sts.out_free   = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (w_we && w_free) begin
            r_valid[r_idx] <= 1'b1;
            r_count        <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_found) begin
            r_res_hit   <= !w_free;
            r_res_upd   <= (r_kind == KIND_INSERT) && !w_free;
            r_res_ref   <= 1'b0;
            r_res_found <= ((r_kind == KIND_LOOKUP) && !w_free) ? w_rd_hnd : '0;
        end else if (i_cmd.commit_full) begin
            r_res_hit   <= 1'b0;
            r_res_upd   <= 1'b0;
            r_res_ref   <= (r_kind == KIND_INSERT);
            r_res_found <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_hit   <= r_res_hit;
            r_out_upd   <= r_res_upd;
            r_out_ref   <= r_res_ref;
            r_out_found <= r_res_found;
            r_out_count <= r_count;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.hit              = r_out_hit;
    assign o_rsp.found_handle     = r_out_found;
    assign o_rsp.updated_existing = r_out_upd;
    assign o_rsp.refused_full     = r_out_ref;
    assign o_rsp.entry_count      = r_out_count;

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count differs from number of occupied slots");

    a_fill_bumps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_free) |=> (r_count == COUNT_BITS'($past(r_count) + 1'b1)))
        else $error("new key stored without count increment");

    a_flags_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!(r_out_hit && r_out_ref) && !(r_out_upd && !r_out_hit)))
        else $error("inconsistent result flags");

    a_miss_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_found == '0))
        else $error("handle reported on a miss");

endmodule

`default_nettype wire

FILE: rtl/linear_probe_hash_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Hash table of 64 slots keyed by (symbol_id, entry_class), one handle per key, with
// linear probing. One item is worked on at a time: the home slot hash is computed in the
// states S_H0 to S_H6 on one shared 32x32 multiplier, then each probed slot is read from
// the single-port slot RAM and then compared, and the result is handed to the output
// register once that register is free. An item probes from 1 to 64 slots; an insert
// refused on a full table has probed all 64. A new item can be accepted in the cycle
// after the previous result enters the output register, even while that result waits.
// Slot occupancy is kept in flip-flops cleared at reset, so the block is ready right
// after reset.
module linear_probe_hash_table_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lpht_req_if.sink  i_req,
    lpht_rsp_if.source o_rsp
);
    import lpht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    lpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    lpht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_req.kind),
        .i_symbol_id   (i_req.symbol_id),
        .i_entry_class (i_req.entry_class),
        .i_handle      (i_req.handle),
        .o_rsp         (o_rsp)
    );

    assign i_req.ready = w_ready;

endmodule

`default_nettype wire
